// ===== rtl/core/frp_pkg.sv =====
// Package for the framed readback step regulator.
// Holds frame constants, register indexes, reset values and shared types.
// No dependencies.
package frp_pkg;

  localparam logic [7:0]  SYNC_LOW   = 8'hF0;
  localparam logic [7:0]  SYNC_HIGH  = 8'hF5;
  localparam logic [15:0] CHECK_WORD = 16'h5555;
  localparam logic [15:0] FULL_WORD  = 16'hFFFF;

  // Bytes held before the last byte of a frame arrives.
  localparam int unsigned FRAME_HELD = 11;
  localparam int unsigned POS_W      = $clog2(FRAME_HELD + 1);

  localparam int unsigned CFG_IDX_W  = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MAX     = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DAC_MIN     = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FAST_STEP   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SLOW_STEP   = 4'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_TARGET = 4'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BIAS_WINDOW = 4'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_TARGET  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_TOP_WINDOW  = 4'd7;

  localparam logic [15:0] RST_DAC_MAX     = 16'h5000;
  localparam logic [15:0] RST_DAC_MIN     = 16'h1A00;
  localparam logic [15:0] RST_FAST_STEP   = 16'd6;
  localparam logic [15:0] RST_SLOW_STEP   = 16'd1;
  localparam logic [15:0] RST_BIAS_TARGET = 16'd40000;
  localparam logic [15:0] RST_BIAS_WINDOW = 16'd6000;
  localparam logic [15:0] RST_TOP_TARGET  = 16'd2000;
  localparam logic [15:0] RST_TOP_WINDOW  = 16'd1000;
  localparam logic [15:0] RST_BIAS_DRIVE  = 16'h3000;
  localparam logic [15:0] RST_TOP_DRIVE   = 16'h1A00;

  typedef struct packed {
    logic [15:0] dac_max;
    logic [15:0] dac_min;
    logic [15:0] fast_step;
    logic [15:0] slow_step;
  } frp_limits_t;

  typedef struct packed {
    logic [7:0]  status;
    logic [15:0] top_one;
    logic [15:0] top_two;
    logic [15:0] bias;
    logic [2:0]  aux_select;
    logic [15:0] aux;
  } frp_frame_t;

endpackage

// ===== rtl/core/framed_readback_step_regulator_unit.sv =====
// Top level of the framed readback step regulator.
// Holds configuration, drive words and the result register.
// Depends on frp_pkg, frp_frame_asm and frp_step_reg.
// A result is registered and valid in the cycle after the last byte of a good frame is taken.
// Throughput: one byte per cycle while no result is stalled; the result register frees as it is taken.
// Reset: asynchronous, active low; hunting, default registers and drives.
module framed_readback_step_regulator_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rx_valid_i,
  output logic                          rx_ready_o,
  input  logic [7:0]                    rx_byte_i,
  input  logic                          cfg_we_i,
  input  logic [frp_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]                   cfg_data_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [7:0]                    status_byte_o,
  output logic [15:0]                   top_one_reading_o,
  output logic [15:0]                   top_two_reading_o,
  output logic [15:0]                   bias_reading_o,
  output logic [2:0]                    aux_select_o,
  output logic [15:0]                   aux_reading_o,
  output logic [15:0]                   bias_dac_o,
  output logic [15:0]                   top_dac_o
);
  import frp_pkg::*;

  frp_limits_t limits_q;
  logic [15:0] bias_target_q, bias_window_q, top_target_q, top_window_q;
  logic [15:0] bias_drive_q, top_drive_q;
  logic [15:0] bias_next, top_next, top_min;
  logic        out_valid_q, out_valid_d;
  logic        rx_acc, frame_ok;
  frp_frame_t  frame;
  frp_frame_t  res_q;
  logic [15:0] res_bias_q, res_top_q;

  assign rx_ready_o = !out_valid_q || out_ready_i;
  assign rx_acc     = rx_valid_i && rx_ready_o;

  frp_frame_asm u_frame (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .byte_acc_i (rx_acc),
    .byte_i     (rx_byte_i),
    .frame_o    (frame),
    .frame_ok_o (frame_ok)
  );

  assign top_min = (frame.top_one >= frame.top_two) ? frame.top_two : frame.top_one;

  frp_step_reg u_bias_reg (
    .limits_i  (limits_q),
    .drive_i   (bias_drive_q),
    .reading_i (frame.bias),
    .target_i  (bias_target_q),
    .window_i  (bias_window_q),
    .drive_o   (bias_next)
  );

  frp_step_reg u_top_reg (
    .limits_i  (limits_q),
    .drive_i   (top_drive_q),
    .reading_i (top_min),
    .target_i  (top_target_q),
    .window_i  (top_window_q),
    .drive_o   (top_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limits_q.dac_max   <= RST_DAC_MAX;
      limits_q.dac_min   <= RST_DAC_MIN;
      limits_q.fast_step <= RST_FAST_STEP;
      limits_q.slow_step <= RST_SLOW_STEP;
      bias_target_q      <= RST_BIAS_TARGET;
      bias_window_q      <= RST_BIAS_WINDOW;
      top_target_q       <= RST_TOP_TARGET;
      top_window_q       <= RST_TOP_WINDOW;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DAC_MAX:     limits_q.dac_max   <= cfg_data_i;
        CFG_DAC_MIN:     limits_q.dac_min   <= cfg_data_i;
        CFG_FAST_STEP:   limits_q.fast_step <= cfg_data_i;
        CFG_SLOW_STEP:   limits_q.slow_step <= cfg_data_i;
        CFG_BIAS_TARGET: bias_target_q      <= cfg_data_i;
        CFG_BIAS_WINDOW: bias_window_q      <= cfg_data_i;
        CFG_TOP_TARGET:  top_target_q       <= cfg_data_i;
        CFG_TOP_WINDOW:  top_window_q       <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (frame_ok) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      bias_drive_q <= RST_BIAS_DRIVE;
      top_drive_q  <= RST_TOP_DRIVE;
    end else begin
      out_valid_q <= out_valid_d;
      if (frame_ok) begin
        bias_drive_q <= bias_next;
        top_drive_q  <= top_next;
      end
    end
  end

  // Result payload is loaded only with a good frame; it needs no reset.
  always_ff @(posedge clk_i) begin
    if (frame_ok) begin
      res_q      <= frame;
      res_bias_q <= bias_next;
      res_top_q  <= top_next;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_byte_o     = res_q.status;
  assign top_one_reading_o = res_q.top_one;
  assign top_two_reading_o = res_q.top_two;
  assign bias_reading_o    = res_q.bias;
  assign aux_select_o      = res_q.aux_select;
  assign aux_reading_o     = res_q.aux;
  assign bias_dac_o        = res_bias_q;
  assign top_dac_o         = res_top_q;

endmodule

// ===== rtl/core/frp_frame_asm.sv =====
// Frame assembler: hunts for a sync byte and collects the frame bytes.
// Flags the last byte of a frame whose check word is good.
// Depends on frp_pkg.
module frp_frame_asm (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               byte_acc_i,
  input  logic [7:0]         byte_i,
  output frp_pkg::frp_frame_t frame_o,
  output logic               frame_ok_o
);
  import frp_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_HELD);

  logic [POS_W-1:0] pos_q, pos_d;
  logic [7:0]       bytes_q [FRAME_HELD];
  logic             is_sync;
  logic             store;

  assign is_sync = (byte_i >= SYNC_LOW) && (byte_i <= SYNC_HIGH);

  always_comb begin
    pos_d = pos_q;
    store = 1'b0;
    if (byte_acc_i) begin
      if (pos_q == '0) begin
        if (is_sync) begin
          pos_d = POS_W'(1);
          store = 1'b1;
        end
      end else if (pos_q < LAST_POS) begin
        pos_d = pos_q + POS_W'(1);
        store = 1'b1;
      end else begin
        pos_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[pos_q] <= byte_i;
    end
  end

  assign frame_ok_o = byte_acc_i && (pos_q == LAST_POS) &&
                      ({bytes_q[10], byte_i} == CHECK_WORD);

  assign frame_o.status     = bytes_q[1];
  assign frame_o.top_one    = {bytes_q[2], bytes_q[3]};
  assign frame_o.top_two    = {bytes_q[4], bytes_q[5]};
  assign frame_o.bias       = {bytes_q[6], bytes_q[7]};
  assign frame_o.aux_select = bytes_q[0][2:0];
  assign frame_o.aux        = {bytes_q[8], bytes_q[9]};

endmodule

// ===== rtl/core/frp_step_reg.sv =====
// One step of a stepping regulator: window compare, step and clamp.
// Purely combinational. Depends on frp_pkg.
module frp_step_reg (
  input  frp_pkg::frp_limits_t limits_i,
  input  logic [15:0]          drive_i,
  input  logic [15:0]          reading_i,
  input  logic [15:0]          target_i,
  input  logic [15:0]          window_i,
  output logic [15:0]          drive_o
);
  import frp_pkg::*;

  logic [15:0] lo;
  logic [16:0] hi_sum;
  logic [15:0] hi;
  logic [15:0] step;
  logic        go_down;
  logic        go_up;
  logic [15:0] dn_raw;
  logic [15:0] dn;
  logic [15:0] up_raw;
  logic [15:0] up;

  // Window bounds saturate at the ends of the 16-bit range.
  assign lo     = (window_i < target_i) ? (target_i - window_i) : '0;
  assign hi_sum = {1'b0, target_i} + {1'b0, window_i};
  assign hi     = hi_sum[16] ? FULL_WORD : hi_sum[15:0];

  always_comb begin
    go_down = 1'b0;
    go_up   = 1'b0;
    step    = limits_i.slow_step;
    if (reading_i > hi) begin
      go_down = 1'b1;
      step    = limits_i.fast_step;
    end else if (reading_i > target_i) begin
      go_down = 1'b1;
    end else if (reading_i < lo) begin
      go_up = 1'b1;
      step  = limits_i.fast_step;
    end else if (reading_i < target_i) begin
      go_up = 1'b1;
    end
  end

  assign dn_raw = (step < drive_i) ? (drive_i - step) : '0;
  assign dn     = (dn_raw < limits_i.dac_min) ? limits_i.dac_min : dn_raw;
  assign up_raw = ((FULL_WORD - step) > drive_i) ? (drive_i + step) : FULL_WORD;
  assign up     = (up_raw > limits_i.dac_max) ? limits_i.dac_max : up_raw;

  assign drive_o = go_down ? dn : (go_up ? up : drive_i);

endmodule

// ===== rtl/core/frp_checker.sv =====
// Port-level checks for the framed readback step regulator.
// Bound to framed_readback_step_regulator_unit. No package dependencies.
module frp_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rx_valid_i,
  input logic        rx_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [7:0]  status_byte_o,
  input logic [2:0]  aux_select_o,
  input logic [15:0] aux_reading_o,
  input logic [15:0] bias_dac_o,
  input logic [15:0] top_dac_o
);

  // A stalled result holds its transaction.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(bias_dac_o) &&
    $stable(top_dac_o) && $stable(aux_reading_o) && $stable(status_byte_o))
    else $error("result changed while stalled");

  // A new result appears only after an input transaction.
  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(rx_valid_i && rx_ready_o))
    else $error("result without input transaction");

  a_next_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i ##1 out_valid_o |-> $past(rx_valid_i && rx_ready_o))
    else $error("back-to-back result without input transaction");

  // The input side stays open unless a result is stalled.
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o || out_ready_i) |-> rx_ready_o)
    else $error("input stalled with free result register");

  // The select comes from a sync byte, so it never exceeds five.
  a_select: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> aux_select_o <= 3'd5)
    else $error("aux select out of range");

endmodule

bind framed_readback_step_regulator_unit frp_checker u_frp_checker (.*);

// ===== tb/testbench.sv =====
// Self-checking testbench for framed_readback_step_regulator_unit.
// Feeds framed link bytes with random gaps, predicts decoded frames and regulator steps,
// and checks every result transaction. Depends on frp_pkg and the RTL top level.
`timescale 1ns / 1ps

module testbench;
  import frp_pkg::*;

  typedef struct packed {
    logic [7:0]  status;
    logic [15:0] top_one;
    logic [15:0] top_two;
    logic [15:0] bias;
    logic [2:0]  aux_sel;
    logic [15:0] aux;
    logic [15:0] bias_dac;
    logic [15:0] top_dac;
  } readback_t;

  logic                 clk_i       = 1'b0;
  logic                 rst_ni      = 1'b0;
  logic                 rx_valid_i  = 1'b0;
  logic                 rx_ready_o;
  logic [7:0]           rx_byte_i   = 8'h00;
  logic                 cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i   = '0;
  logic [15:0]          cfg_data_i  = 16'h0000;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [7:0]           status_byte_o;
  logic [15:0]          top_one_reading_o;
  logic [15:0]          top_two_reading_o;
  logic [15:0]          bias_reading_o;
  logic [2:0]           aux_select_o;
  logic [15:0]          aux_reading_o;
  logic [15:0]          bias_dac_o;
  logic [15:0]          top_dac_o;

  framed_readback_step_regulator_unit u_top (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_valid_i),
    .rx_ready_o        (rx_ready_o),
    .rx_byte_i         (rx_byte_i),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .status_byte_o     (status_byte_o),
    .top_one_reading_o (top_one_reading_o),
    .top_two_reading_o (top_two_reading_o),
    .bias_reading_o    (bias_reading_o),
    .aux_select_o      (aux_select_o),
    .aux_reading_o     (aux_reading_o),
    .bias_dac_o        (bias_dac_o),
    .top_dac_o         (top_dac_o)
  );

  always #1 clk_i = ~clk_i;

  // Stimulus and expectation stores.
  logic [7:0] pending_bytes [$];
  readback_t  expected_readbacks [$];
  int         err_count = 0;

  // Shadow of the block: registers, frame assembly and both drive words.
  // One entry per register index; indexes past the list are never read.
  logic [15:0] reg_file [16] = '{0: RST_DAC_MAX, 1: RST_DAC_MIN, 2: RST_FAST_STEP,
                                 3: RST_SLOW_STEP, 4: RST_BIAS_TARGET,
                                 5: RST_BIAS_WINDOW, 6: RST_TOP_TARGET,
                                 7: RST_TOP_WINDOW, default: 16'h0000};
  logic [3:0]  hunt_pos = 4'd0;
  logic [7:0]  held [FRAME_HELD];
  logic [15:0] bias_drv = RST_BIAS_DRIVE;
  logic [15:0] top_drv  = RST_TOP_DRIVE;

  // Handshake pacing shared between the clocked processes.
  bit rx_taken  = 1'b0;
  int rx_gap    = 0;
  bit rx_burst  = 1'b0;
  int out_wait  = 0;
  bit out_burst = 1'b0;
  int cyc_count = 0;
  logic long_hold = 1'b0;

  function automatic logic [15:0] lower_drive(input logic [15:0] drv, input logic [15:0] step);
    logic [15:0] d;
    d = (step < drv) ? drv - step : 16'h0000;
    return (d < reg_file[CFG_DAC_MIN]) ? reg_file[CFG_DAC_MIN] : d;
  endfunction

  function automatic logic [15:0] raise_drive(input logic [15:0] drv, input logic [15:0] step);
    logic [15:0] d;
    d = ((FULL_WORD - step) > drv) ? drv + step : FULL_WORD;
    return (d > reg_file[CFG_DAC_MAX]) ? reg_file[CFG_DAC_MAX] : d;
  endfunction

  function automatic logic [15:0] window_low(input logic [15:0] t, input logic [15:0] w);
    return (w < t) ? t - w : 16'h0000;
  endfunction

  function automatic logic [15:0] window_high(input logic [15:0] t, input logic [15:0] w);
    logic [16:0] hs;
    hs = {1'b0, t} + {1'b0, w};
    return (hs > {1'b0, FULL_WORD}) ? FULL_WORD : hs[15:0];
  endfunction

  function automatic logic [15:0] next_drive(input logic [15:0] drv, input logic [15:0] r,
                                             input logic [15:0] t, input logic [15:0] w);
    if (r > window_high(t, w)) return lower_drive(drv, reg_file[CFG_FAST_STEP]);
    if (r > t)                 return lower_drive(drv, reg_file[CFG_SLOW_STEP]);
    if (r < window_low(t, w))  return raise_drive(drv, reg_file[CFG_FAST_STEP]);
    if (r < t)                 return raise_drive(drv, reg_file[CFG_SLOW_STEP]);
    return drv;
  endfunction

  // Advances the shadow by one accepted byte and queues a readback on a good frame.
  task automatic absorb_byte(input logic [7:0] b);
    readback_t   rb;
    logic [15:0] low_top;
    if (hunt_pos == 4'd0) begin
      if (b >= SYNC_LOW && b <= SYNC_HIGH) begin
        held[0]  = b;
        hunt_pos = 4'd1;
      end
    end else if (hunt_pos < FRAME_HELD) begin
      held[hunt_pos] = b;
      hunt_pos++;
    end else begin
      hunt_pos = 4'd0;
      if ({held[10], b} == CHECK_WORD) begin
        rb.status  = held[1];
        rb.top_one = {held[2], held[3]};
        rb.top_two = {held[4], held[5]};
        rb.bias    = {held[6], held[7]};
        rb.aux_sel = held[0][2:0];
        rb.aux     = {held[8], held[9]};
        low_top    = (rb.top_one >= rb.top_two) ? rb.top_two : rb.top_one;
        bias_drv   = next_drive(bias_drv, rb.bias, reg_file[CFG_BIAS_TARGET],
                                reg_file[CFG_BIAS_WINDOW]);
        top_drv    = next_drive(top_drv, low_top, reg_file[CFG_TOP_TARGET],
                                reg_file[CFG_TOP_WINDOW]);
        rb.bias_dac = bias_drv;
        rb.top_dac  = top_drv;
        expected_readbacks.push_back(rb);
      end
    end
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      err_count++;
    end
  endtask

  function automatic int idle_draw(input bit burst);
    return burst ? 0 : $urandom_range(0, 6);
  endfunction

  // Samples both channels at the rising edge; input transactions feed the shadow first.
  always @(posedge clk_i) begin
    readback_t rb;
    if (rst_ni) begin
      if (rx_valid_i && rx_ready_o) begin
        absorb_byte(rx_byte_i);
        rx_taken = 1'b1;
        if ($urandom_range(0, 39) == 0) rx_burst = !rx_burst;
        rx_gap = idle_draw(rx_burst);
      end
      if (out_valid_o && out_ready_i) begin
        if (expected_readbacks.size() == 0) begin
          $error("result transaction with no expected readback pending");
          err_count++;
        end else begin
          rb = expected_readbacks.pop_front();
          check_field("status_byte", 16'(rb.status), 16'(status_byte_o));
          check_field("top_one_reading", rb.top_one, top_one_reading_o);
          check_field("top_two_reading", rb.top_two, top_two_reading_o);
          check_field("bias_reading", rb.bias, bias_reading_o);
          check_field("aux_select", 16'(rb.aux_sel), 16'(aux_select_o));
          check_field("aux_reading", rb.aux, aux_reading_o);
          check_field("bias_dac", rb.bias_dac, bias_dac_o);
          check_field("top_dac", rb.top_dac, top_dac_o);
        end
        if ($urandom_range(0, 19) == 0) out_burst = !out_burst;
        out_wait = idle_draw(out_burst);
      end
    end
  end

  // Byte driver: holds a byte until it is taken, then idles for the drawn gap.
  always @(negedge clk_i) begin
    if (rst_ni && !(rx_valid_i && !rx_taken)) begin
      rx_taken = 1'b0;
      if (rx_gap != 0) begin
        rx_gap--;
        rx_valid_i <= 1'b0;
      end else if (pending_bytes.size() != 0) begin
        rx_byte_i  <= pending_bytes.pop_front();
        rx_valid_i <= 1'b1;
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
  end

  // Periodic long back-pressure window so the result register fills and stalls input.
  always @(negedge clk_i) begin
    cyc_count++;
    long_hold <= (cyc_count % 3000) >= 2600;
  end

  always @(negedge clk_i) begin
    if (!rst_ni || long_hold) begin
      out_ready_i <= 1'b0;
    end else if (out_wait != 0) begin
      out_wait--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic push_word(input logic [15:0] w);
    pending_bytes.push_back(w[15:8]);
    pending_bytes.push_back(w[7:0]);
  endtask

  task automatic push_frame(input logic [7:0] sync, input logic [7:0] status,
                            input logic [15:0] t1, input logic [15:0] t2,
                            input logic [15:0] bias, input logic [15:0] aux,
                            input logic [15:0] check);
    pending_bytes.push_back(sync);
    pending_bytes.push_back(status);
    push_word(t1);
    push_word(t2);
    push_word(bias);
    push_word(aux);
    push_word(check);
  endtask

  // Readings clustered on the target and window edges, with some full-range values.
  function automatic logic [15:0] pick_reading(input logic [15:0] t, input logic [15:0] w);
    logic [15:0] lo;
    logic [15:0] hi;
    lo = window_low(t, w);
    hi = window_high(t, w);
    case ($urandom_range(0, 10))
      0:       return t;
      1:       return t + 16'd1;
      2:       return t - 16'd1;
      3:       return lo;
      4:       return lo - 16'd1;
      5:       return hi;
      6:       return hi + 16'd1;
      7:       return $urandom_range(0, 1) ? FULL_WORD : 16'h0000;
      8, 9:    return t + 16'($urandom_range(0, 2 * w)) - w;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic send_random(input int n_bytes);
    int          start;
    int          kind;
    int          n;
    logic [15:0] a;
    logic [15:0] b;
    logic [15:0] check;
    start = pending_bytes.size();
    while (pending_bytes.size() - start < n_bytes) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        a = pick_reading(reg_file[CFG_TOP_TARGET], reg_file[CFG_TOP_WINDOW]);
        b = ($urandom_range(0, 3) == 0) ? a : 16'($urandom);
        if ($urandom_range(0, 1)) {a, b} = {b, a};
        check = CHECK_WORD;
        // Some frames carry a corrupted check word and must be dropped.
        if (kind >= 72)
          check = ($urandom_range(0, 1)) ? CHECK_WORD ^ (16'd1 << $urandom_range(0, 15))
                                         : 16'($urandom) | 16'h8000;
        push_frame(SYNC_LOW + 8'($urandom_range(0, 5)), 8'($urandom), a, b,
                   pick_reading(reg_file[CFG_BIAS_TARGET], reg_file[CFG_BIAS_WINDOW]),
                   16'($urandom), check);
      end else if (kind < 92) begin
        // Truncated frame: the following bytes get absorbed into it.
        pending_bytes.push_back(SYNC_LOW + 8'($urandom_range(0, 5)));
        n = $urandom_range(0, 9);
        repeat (n) pending_bytes.push_back(8'($urandom));
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) pending_bytes.push_back(8'($urandom));
      end
    end
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    if (idx < 8) reg_file[idx] = data;
  endtask

  task automatic load_settings(input logic [15:0] mx, input logic [15:0] mn,
                               input logic [15:0] fast, input logic [15:0] slow,
                               input logic [15:0] bt, input logic [15:0] bw,
                               input logic [15:0] tt, input logic [15:0] tw);
    cfg_write(CFG_DAC_MAX, mx);
    cfg_write(CFG_DAC_MIN, mn);
    cfg_write(CFG_FAST_STEP, fast);
    cfg_write(CFG_SLOW_STEP, slow);
    cfg_write(CFG_BIAS_TARGET, bt);
    cfg_write(CFG_BIAS_WINDOW, bw);
    cfg_write(CFG_TOP_TARGET, tt);
    cfg_write(CFG_TOP_WINDOW, tw);
    // An index past the register list must leave everything unchanged.
    cfg_write(CFG_IDX_W'($urandom_range(8, 15)), 16'($urandom));
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Waits until every byte is taken and every readback has come out.
  task automatic drain();
    while (pending_bytes.size() != 0 || rx_valid_i || expected_readbacks.size() != 0)
      @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [15:0] mx;
    logic [15:0] mn;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: a non-sync byte, bytes just outside the sync range, a select-five
    // frame at the field extremes, then a frame whose check word is one bit off.
    pending_bytes.push_back(8'h00);
    pending_bytes.push_back(8'hEF);
    pending_bytes.push_back(8'hF6);
    push_frame(SYNC_HIGH, 8'hFF, FULL_WORD, 16'h0000, FULL_WORD, FULL_WORD, CHECK_WORD);
    push_frame(SYNC_LOW, 8'h00, 16'h0000, FULL_WORD, 16'h0000, 16'h0000, 16'h5554);
    drain();

    send_random(160);
    drain();

    load_settings(FULL_WORD, 16'h0000, FULL_WORD, FULL_WORD,
                  16'h0000, 16'h0000, FULL_WORD, FULL_WORD);
    send_random(160);
    drain();

    // Lower clamp above upper clamp.
    load_settings(16'h1000, 16'h8000, 16'h0123, 16'h0011,
                  16'h8000, 16'h7FFF, 16'h0400, 16'h0000);
    send_random(160);
    drain();

    load_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000,
                  FULL_WORD, FULL_WORD, 16'h0000, 16'h0000);
    send_random(120);
    drain();

    repeat (5) begin
      mx = 16'($urandom);
      mn = 16'($urandom);
      if (mn > mx && $urandom_range(0, 4) != 0) {mx, mn} = {mn, mx};
      load_settings(mx, mn, 16'($urandom_range(0, 3000)), 16'($urandom_range(0, 200)),
                    16'($urandom), 16'($urandom_range(0, 16'h4000)),
                    16'($urandom), 16'($urandom_range(0, 16'h4000)));
      send_random(150);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (err_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #400000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/frp_pkg.sv
rtl/core/frp_frame_asm.sv
rtl/core/frp_step_reg.sv
rtl/core/framed_readback_step_regulator_unit.sv
rtl/core/frp_checker.sv
tb/testbench.sv
